/* rtl/core/compass_edge_3x3_filter_assert.svh */
// Assertion macros shared by the filter RTL.
// Every check is sampled on the rising edge of clk and is off while arst_n is low.
`ifndef COMPASS_EDGE_3X3_FILTER_ASSERT_SVH
`define COMPASS_EDGE_3X3_FILTER_ASSERT_SVH

// A condition that must hold on every clock edge.
`define CEF_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold on the same edge as its cause.
`define CEF_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/cef_pkg.sv */
package cef_pkg;

	// Default bounds on the frame size.
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Register file layout.
	localparam int PADDR_W    = 5;
	localparam int CFG_SIZE_W = 13;
	localparam int MASK_W     = 12;

	localparam logic [CFG_SIZE_W-1:0] RST_FRAME_WIDTH  = 13'd640;
	localparam logic [CFG_SIZE_W-1:0] RST_FRAME_HEIGHT = 13'd480;
	localparam logic [MASK_W-1:0]     RST_MASK_TOP     = 12'd271;
	localparam logic [MASK_W-1:0]     RST_MASK_MIDDLE  = 12'd526;
	localparam logic [MASK_W-1:0]     RST_MASK_BOTTOM  = 12'd271;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_MASK_TOP     = 3'd2,
		REG_MASK_MIDDLE  = 3'd3,
		REG_MASK_BOTTOM  = 3'd4
	} reg_idx_t;

	// Kinds of input word.
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	// Width of the signed window sum: nine taps of 4-bit by 8-bit.
	localparam int SUM_W = 16;

	// Depth of the result queue in front of the output port.
	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic       req_type;
		logic [7:0] pixel_in;
	} pix_word_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       frame_last;
	} res_word_t;

	// Tap masking and bookkeeping for one result, carried down the pipeline.
	typedef struct packed {
		logic emit;
		logic last;
		logic m_top;
		logic m_bot;
		logic m_left;
		logic m_right;
	} tap_ctl_t;

endpackage

/* rtl/core/compass_edge_3x3_filter.sv */
// 3x3 compass edge filter. Grayscale pixels enter in raster order on the pix channel, one word
// per clock, and every image position is convolved with a signed 4-bit 3x3 mask held in three
// registers. Neighbors outside the frame count as zero. The result word carries the low 8 bits
// of the absolute sum, and frame_last marks the final position of the frame. A result belongs
// to the pixel that entered frame_width+1 pixel words earlier. After the last pixel of a frame,
// frame_width+1 drain words (req_type = 1) push out the remaining results. A pixel word sent
// while draining, and a drain word sent while not draining, is taken and dropped. The block
// sustains one word per clock while pix_stall is low. That rate is set by the line memory:
// each word makes one read and one write of the entry for its column, the read data
// returning in the next cycle. A result word passes the stage-1 and stage-2 registers and
// the result queue before it shows on the output. A four-word result queue decouples the
// output, and pix_stall rises only when that queue could otherwise overflow.
// The line memory holds two rows per column, is not cleared after reset, and needs no
// clearing pass: entries that were never written only ever feed masked taps. frame_width and
// frame_height are used clamped to the range 2 to MAX_WIDTH or MAX_HEIGHT. Write the
// registers only while no frame is in flight.
`include "compass_edge_3x3_filter_assert.svh"
module compass_edge_3x3_filter #(
	parameter int MAX_WIDTH  = cef_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cef_pkg::DEF_MAX_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cef_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         pix_valid,
	output logic                         pix_stall,
	input  cef_pkg::pix_word_t           pix_word,
	output logic                         res_valid,
	input  logic                         res_stall,
	output cef_pkg::res_word_t           res_word
);
	import cef_pkg::*;

	localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int HW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int FP_W  = $clog2(FIFO_DEPTH);
	localparam int CNT_W = FP_W + 2;
	localparam logic [AW-1:0] W_LAST_MAX = AW'(MAX_WIDTH - 1);
	localparam logic [HW-1:0] H_LAST_MAX = HW'(MAX_HEIGHT - 1);

	// ---------------------------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------------------------
	logic [CFG_SIZE_W-1:0] frame_width_q;
	logic [CFG_SIZE_W-1:0] frame_height_q;
	logic [MASK_W-1:0]     mask_top_q;
	logic [MASK_W-1:0]     mask_mid_q;
	logic [MASK_W-1:0]     mask_bot_q;
	logic                  cfg_wr;
	reg_idx_t              cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			mask_top_q     <= RST_MASK_TOP;
			mask_mid_q     <= RST_MASK_MIDDLE;
			mask_bot_q     <= RST_MASK_BOTTOM;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_SIZE_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_SIZE_W-1:0];
				REG_MASK_TOP:     mask_top_q     <= pwdata[MASK_W-1:0];
				REG_MASK_MIDDLE:  mask_mid_q     <= pwdata[MASK_W-1:0];
				REG_MASK_BOTTOM:  mask_bot_q     <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			REG_MASK_TOP:     prdata = 32'(mask_top_q);
			REG_MASK_MIDDLE:  prdata = 32'(mask_mid_q);
			REG_MASK_BOTTOM:  prdata = 32'(mask_bot_q);
			default:          prdata = '0;
		endcase
	end

	// Last column and last row of the frame, after clamping the size registers.
	logic [31:0]   width_ext;
	logic [31:0]   height_ext;
	logic [AW-1:0] col_last;
	logic [HW-1:0] row_last;

	assign width_ext  = 32'(frame_width_q);
	assign height_ext = 32'(frame_height_q);
	assign col_last   = (width_ext < 32'd2) ? AW'(1) :
			(width_ext > 32'(MAX_WIDTH)) ? W_LAST_MAX : AW'(width_ext - 32'd1);
	assign row_last   = (height_ext < 32'd2) ? HW'(1) :
			(height_ext > 32'(MAX_HEIGHT)) ? H_LAST_MAX : HW'(height_ext - 32'd1);

	// ---------------------------------------------------------------------------------------
	// Position tracking, done at accept time
	// ---------------------------------------------------------------------------------------
	// The input position walks the frame as pixels arrive; the output position trails it by
	// one row and one column. Both are pure control, so they advance on the accepting edge and
	// the tap masks for the result travel with the word.
	logic [AW-1:0] in_column_q, in_column_d;
	logic [HW-1:0] in_row_q, in_row_d;
	logic [AW-1:0] out_column_q, out_column_d;
	logic [HW-1:0] out_row_q, out_row_d;
	logic          draining_q, draining_d;
	logic          is_drain;
	logic          take;
	logic          due;
	logic          in_col_wrap;
	tap_ctl_t      ctl_s0;

	assign is_drain    = (pix_word.req_type == REQ_DRAIN);
	assign take        = pix_valid && !pix_stall && (is_drain == draining_q);
	assign in_col_wrap = (in_column_q >= col_last);
	assign due         = (32'(in_row_q) >= 32'd2) ||
			((32'(in_row_q) == 32'd1) && (in_column_q != '0));

	always_comb begin
		in_column_d  = in_column_q;
		in_row_d     = in_row_q;
		out_column_d = out_column_q;
		out_row_d    = out_row_q;
		draining_d   = draining_q;

		ctl_s0.emit    = 1'b0;
		ctl_s0.m_top   = (out_row_q == '0);
		ctl_s0.m_bot   = (out_row_q >= row_last);
		ctl_s0.m_left  = (out_column_q == '0);
		ctl_s0.m_right = (out_column_q >= col_last);
		ctl_s0.last    = ctl_s0.m_bot && ctl_s0.m_right;

		if (take) begin
			if (!is_drain) begin
				ctl_s0.emit = due;
				if ((in_row_q >= row_last) && in_col_wrap) begin
					in_column_d = '0;
					in_row_d    = '0;
					draining_d  = 1'b1;
				end else if (in_col_wrap) begin
					in_column_d = '0;
					in_row_d    = in_row_q + HW'(1);
				end else begin
					in_column_d = in_column_q + AW'(1);
				end
			end else begin
				ctl_s0.emit = 1'b1;
				in_column_d = in_col_wrap ? '0 : in_column_q + AW'(1);
			end
		end

		if (ctl_s0.emit) begin
			if (ctl_s0.last) begin
				// Frame done: everything returns to the top-left corner.
				in_column_d  = '0;
				in_row_d     = '0;
				out_column_d = '0;
				out_row_d    = '0;
				draining_d   = 1'b0;
			end else if (ctl_s0.m_right) begin
				out_column_d = '0;
				out_row_d    = out_row_q + HW'(1);
			end else begin
				out_column_d = out_column_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_column_q  <= '0;
			in_row_q     <= '0;
			out_column_q <= '0;
			out_row_q    <= '0;
			draining_q   <= 1'b0;
		end else begin
			in_column_q  <= in_column_d;
			in_row_q     <= in_row_d;
			out_column_q <= out_column_d;
			out_row_q    <= out_row_d;
			draining_q   <= draining_d;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Stage 1: line memory read-modify-write and window shift
	// ---------------------------------------------------------------------------------------
	// Each entry holds the column's pixel one row up in the low byte and two rows up in the
	// high byte. The read is issued on the accepting edge, and the entry is rewritten in the next
	// cycle with the row above moved up and the new pixel below it. Consecutive words hit the
	// same column only across a frame boundary (the last drain word and the first pixel of the
	// next frame both sit in column zero), and a bypass covers a read of the entry that is
	// being written.
	logic [15:0]   line_mem [MAX_WIDTH];
	logic [15:0]   mem_rd_s1;
	logic [15:0]   fwd_data_s1;
	logic          fwd_s1;
	logic [15:0]   rd_s1;
	logic [7:0]    above_s1;
	logic [7:0]    above2_s1;
	logic          v_s1;
	tap_ctl_t      ctl_s1;
	logic [AW-1:0] col_s1;
	logic [7:0]    pix_s1;

	assign rd_s1     = fwd_s1 ? fwd_data_s1 : mem_rd_s1;
	assign above_s1  = rd_s1[7:0];
	assign above2_s1 = rd_s1[15:8];

	always_ff @(posedge clk) begin
		if (v_s1) begin
			line_mem[col_s1] <= {above_s1, pix_s1};
		end
		if (take) begin
			mem_rd_s1 <= line_mem[in_column_q];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_s1      <= in_column_q;
			pix_s1      <= is_drain ? 8'd0 : pix_word.pixel_in;
			fwd_s1      <= v_s1 && (col_s1 == in_column_q);
			fwd_data_s1 <= {above_s1, pix_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			ctl_s1 <= '0;
		end else begin
			v_s1   <= take;
			ctl_s1 <= ctl_s0;
		end
	end

	// The window after the shift: two old columns move left, the new column comes in right.
	logic [7:0] win_q  [3][3];
	logic [7:0] win_nx [3][3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_nx[r][0] = win_q[r][1];
			win_nx[r][1] = win_q[r][2];
		end
		win_nx[0][2] = above2_s1;
		win_nx[1][2] = above_s1;
		win_nx[2][2] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (v_s1) begin
			win_q <= win_nx;
		end
	end

	// Nine taps, with rows and columns outside the frame masked off.
	logic [MASK_W-1:0]        mask_row [3];
	logic signed [12:0]       prod     [3][3];
	logic signed [SUM_W-1:0]  sum_s1;

	assign mask_row[0] = mask_top_q;
	assign mask_row[1] = mask_mid_q;
	assign mask_row[2] = mask_bot_q;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod[r][c] = $signed(mask_row[r][4*c +: 4]) * $signed({1'b0, win_nx[r][c]});
			end
		end
	end

	always_comb begin
		sum_s1 = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!((r == 0 && ctl_s1.m_top) || (r == 2 && ctl_s1.m_bot) ||
						(c == 0 && ctl_s1.m_left) || (c == 2 && ctl_s1.m_right))) begin
					sum_s1 = sum_s1 + SUM_W'(prod[r][c]);
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// Stage 2: magnitude and result queue
	// ---------------------------------------------------------------------------------------
	logic                    e_s1;
	logic                    e_s2;
	logic signed [SUM_W-1:0] sum_s2;
	logic                    last_s2;
	logic [SUM_W-1:0]        mag_s2;
	res_word_t               res_s2;

	assign e_s1 = v_s1 && ctl_s1.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_s2 <= 1'b0;
		end else begin
			e_s2 <= e_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (e_s1) begin
			sum_s2  <= sum_s1;
			last_s2 <= ctl_s1.last;
		end
	end

	assign mag_s2 = sum_s2[SUM_W-1] ? SUM_W'(-sum_s2) : SUM_W'(sum_s2);
	assign res_s2 = res_word_t'{pixel_out: mag_s2[7:0], frame_last: last_s2};

	// Results in flight are counted against the queue, so an accepted word always finds room.
	res_word_t       fifo_mem [FIFO_DEPTH];
	logic [FP_W-1:0] wr_ptr_q;
	logic [FP_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fifo_count_q;
	logic             pop;
	logic [CNT_W-1:0] committed;

	assign pop       = res_valid && !res_stall;
	assign res_valid = (fifo_count_q != '0);
	assign res_word  = fifo_mem[rd_ptr_q];
	assign committed = fifo_count_q + CNT_W'(e_s1) + CNT_W'(e_s2);
	assign pix_stall = (committed >= CNT_W'(FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (e_s2) begin
			fifo_mem[wr_ptr_q] <= res_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			fifo_count_q <= '0;
		end else begin
			if (e_s2) begin
				wr_ptr_q <= wr_ptr_q + FP_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FP_W'(1);
			end
			fifo_count_q <= fifo_count_q + CNT_W'(e_s2) - CNT_W'(pop);
		end
	end

	// ---------------------------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------------------------
	logic fifo_room;
	logic pos_at_start;

	assign fifo_room    = (fifo_count_q < CNT_W'(FIFO_DEPTH));
	assign pos_at_start = !draining_q && (out_row_q == '0) && (out_column_q == '0) &&
			(in_row_q == '0);

	// The credit check on pix_stall must keep the result queue from overflowing.
	`CEF_ASSERT_IMPLIES(a_fifo_no_overflow, e_s2 && !pop, fifo_room, "result queue overflow")
	// Draining starts at the last pixel of a frame, so the input row stays at zero meanwhile.
	`CEF_ASSERT_IMPLIES(a_drain_row_zero, draining_q, in_row_q == '0, "row moved while draining")
	// The last result of a frame must leave every position at the frame start.
	`CEF_ASSERT_IMPLIES(a_frame_restart, e_s1 && ctl_s1.last, pos_at_start, "no frame restart")

endmodule

/* sim/tb_compass_edge_3x3_filter.sv */
// Testbench for the 3x3 compass edge filter.
//
// Pixel words go in on the pix channel and result words come out on the res channel. A
// behavioral copy of the filter in this file follows every accepted word. It keeps its own
// line memory, 3x3 window, input and output positions and register copies, and it queues the
// result word that each accepted word is due to produce. A monitor pops the oldest queued word
// for each result taken from the block and compares it field by field. Registers are written
// over the APB-style port, and only while no frame is in flight.
module tb_compass_edge_3x3_filter;
	import cef_pkg::*;

	localparam int unsigned MAXW = DEF_MAX_WIDTH;
	localparam int unsigned MAXH = DEF_MAX_HEIGHT;

	// The slowest correct run stays well below this.
	localparam int unsigned CYCLE_LIMIT = 100000;

	// Input words sent over the whole run after which no new random frame is started.
	localparam int unsigned TOTAL_WORDS = 1150;

	// Idle time after the last queued result, to cover words that produce no result but may
	// still be in the pipeline.
	localparam int unsigned SETTLE_CYCLES = 16;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              pix_valid;
	logic              pix_stall;
	pix_word_t         pix_word;
	logic              res_valid;
	logic              res_stall;
	res_word_t         res_word;

	compass_edge_3x3_filter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_word  (pix_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Behavioral copy of the filter. The line memory holds two rows per column: the entry at
	// 2*col is the row just above, the entry at 2*col+1 the row above that.
	logic [CFG_SIZE_W-1:0] cfg_width;
	logic [CFG_SIZE_W-1:0] cfg_height;
	logic [MASK_W-1:0]     mask_row [0:2];
	logic [7:0]            line_mem [0:2*MAXW-1];
	logic [7:0]            win      [0:2][0:2];
	int unsigned           col_in;
	int unsigned           row_in;
	int unsigned           col_out;
	int unsigned           row_out;
	bit                    flushing;

	// Result words that the block still owes, oldest first.
	res_word_t edge_queue [$];

	int unsigned error_count;
	int unsigned sent_words;
	int unsigned cycle_count;
	bit          idle_on;
	res_word_t   want;

	// Frame sizes are used clamped to the range the block supports.
	function automatic int unsigned size_used(logic [CFG_SIZE_W-1:0] raw, int unsigned top);
		if (raw < 2)
			return 2;
		if (raw > top)
			return top;
		return 32'(raw);
	endfunction

	// Shift the window one column left and load the new right column from the line memory.
	function automatic void shift_column(int unsigned col, logic [7:0] pix);
		int unsigned idx;
		logic [7:0] up1;
		logic [7:0] up2;
		int rr;
		idx = (col % MAXW) * 2;
		up1 = line_mem[idx];
		up2 = line_mem[idx+1];
		line_mem[idx+1] = up1;
		line_mem[idx] = pix;
		for (rr = 0; rr < 3; rr++) begin
			win[rr][0] = win[rr][1];
			win[rr][1] = win[rr][2];
		end
		win[0][2] = up2;
		win[1][2] = up1;
		win[2][2] = pix;
	endfunction

	// Convolve at the output position, skipping taps that fall outside the frame, then move
	// the output position on. The final position of a frame resets every position.
	function automatic res_word_t convolve_position(int unsigned w, int unsigned h);
		int acc;
		int tap;
		int rr;
		int cc;
		bit fin;
		res_word_t word;
		acc = 0;
		for (rr = 0; rr < 3; rr++) begin
			for (cc = 0; cc < 3; cc++) begin
				if ((rr == 0 && row_out == 0) || (rr == 2 && row_out >= h - 1) ||
				    (cc == 0 && col_out == 0) || (cc == 2 && col_out >= w - 1))
					continue;
				tap = int'($signed(mask_row[rr][4*cc +: 4]));
				acc += tap * int'(win[rr][cc]);
			end
		end
		if (acc < 0)
			acc = -acc;
		fin = (row_out >= h - 1) && (col_out >= w - 1);
		word.pixel_out = acc[7:0];
		word.frame_last = fin;
		if (fin) begin
			col_in = 0;
			row_in = 0;
			col_out = 0;
			row_out = 0;
			flushing = 1'b0;
		end else if (col_out + 1 >= w) begin
			col_out = 0;
			row_out++;
		end else begin
			col_out++;
		end
		return word;
	endfunction

	// Follow one accepted word and queue the result it produces, if any.
	function automatic void apply_edge_step(pix_word_t word);
		int unsigned w;
		int unsigned h;
		bit due;
		w = size_used(cfg_width, MAXW);
		h = size_used(cfg_height, MAXH);
		if (word.req_type == REQ_PIXEL) begin
			// A pixel word that arrives while the frame is draining is dropped.
			if (flushing)
				return;
			shift_column(col_in, word.pixel_in);
			due = (row_in >= 2) || (row_in == 1 && col_in >= 1);
			if (row_in >= h - 1 && col_in >= w - 1) begin
				col_in = 0;
				row_in = 0;
				flushing = 1'b1;
			end else if (col_in + 1 >= w) begin
				col_in = 0;
				row_in++;
			end else begin
				col_in++;
			end
			if (due)
				edge_queue.push_back(convolve_position(w, h));
		end else begin
			// A drain word outside the draining phase is dropped as well.
			if (!flushing)
				return;
			shift_column(col_in, 8'd0);
			if (col_in + 1 >= w)
				col_in = 0;
			else
				col_in++;
			edge_queue.push_back(convolve_position(w, h));
		end
	endfunction

	// Pixel values lean toward the two extremes now and then.
	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Send one word and wait until the block takes it. Valid stays high into the next word
	// unless random idle cycles are inserted before it.
	task automatic send_word(pix_word_t word);
		while (idle_on && $urandom_range(99) < 14) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_word <= word;
		do
			@(posedge clk);
		while (pix_stall);
		apply_edge_step(word);
		sent_words++;
	endtask

	// Drop valid and wait until every owed result has come out and the pipeline is empty.
	task automatic settle_block();
		pix_valid <= 1'b0;
		while (edge_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: a setup cycle, then an access cycle that completes when pready is high.
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:  cfg_width = value[CFG_SIZE_W-1:0];
			REG_FRAME_HEIGHT: cfg_height = value[CFG_SIZE_W-1:0];
			REG_MASK_TOP:     mask_row[0] = value[MASK_W-1:0];
			REG_MASK_MIDDLE:  mask_row[1] = value[MASK_W-1:0];
			REG_MASK_BOTTOM:  mask_row[2] = value[MASK_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_masks(logic [MASK_W-1:0] top, logic [MASK_W-1:0] mid,
			logic [MASK_W-1:0] bot);
		write_reg(REG_MASK_TOP, 32'(top));
		write_reg(REG_MASK_MIDDLE, 32'(mid));
		write_reg(REG_MASK_BOTTOM, 32'(bot));
	endtask

	// One complete frame with random content, followed by the width+1 drain words that flush
	// it. With noise_pct above zero, stray drain words are mixed into the pixel phase and stray
	// pixel words into the drain phase; the block must drop both.
	task automatic send_frame(int unsigned noise_pct);
		int unsigned w;
		int unsigned h;
		int unsigned n;
		w = size_used(cfg_width, MAXW);
		h = size_used(cfg_height, MAXH);
		for (n = 0; n < w * h; n++) begin
			if ($urandom_range(99) < noise_pct)
				send_word(pix_word_t'{req_type: REQ_DRAIN, pixel_in: pick_pixel()});
			send_word(pix_word_t'{req_type: REQ_PIXEL, pixel_in: pick_pixel()});
		end
		for (n = 0; n <= w; n++) begin
			if ($urandom_range(99) < noise_pct)
				send_word(pix_word_t'{req_type: REQ_PIXEL, pixel_in: pick_pixel()});
			send_word(pix_word_t'{req_type: REQ_DRAIN, pixel_in: pick_pixel()});
		end
	endtask

	// The smallest frame under the reset mask. The size registers get 1 and 0, which the block
	// must clamp to 2. A drain word before the frame, a pixel word while it drains and a drain
	// word after it has ended must all be dropped.
	task automatic test_reset_mask();
		write_reg(REG_FRAME_WIDTH, 32'd1);
		write_reg(REG_FRAME_HEIGHT, 32'd0);
		send_word(pix_word_t'{req_type: REQ_DRAIN, pixel_in: 8'hFF});
		send_word(pix_word_t'{req_type: REQ_PIXEL, pixel_in: 8'hFF});
		send_word(pix_word_t'{req_type: REQ_PIXEL, pixel_in: 8'h00});
		send_word(pix_word_t'{req_type: REQ_PIXEL, pixel_in: 8'h00});
		send_word(pix_word_t'{req_type: REQ_PIXEL, pixel_in: 8'hFF});
		send_word(pix_word_t'{req_type: REQ_PIXEL, pixel_in: 8'hAA});
		repeat (3) send_word(pix_word_t'{req_type: REQ_DRAIN, pixel_in: 8'h55});
		send_word(pix_word_t'{req_type: REQ_DRAIN, pixel_in: 8'h00});
		settle_block();
	endtask

	// The most negative and the most positive coefficients everywhere. Full-scale pixels make
	// the widest sums, so the low byte of the absolute value is exercised near its limits.
	task automatic test_mask_extremes();
		int n;
		write_reg(REG_FRAME_WIDTH, 32'd3);
		write_reg(REG_FRAME_HEIGHT, 32'd2);
		write_masks(12'h888, 12'h888, 12'h888);
		repeat (6) send_word(pix_word_t'{req_type: REQ_PIXEL, pixel_in: 8'hFF});
		repeat (4) send_word(pix_word_t'{req_type: REQ_DRAIN, pixel_in: 8'h00});
		settle_block();
		write_masks(12'h777, 12'h777, 12'h777);
		for (n = 0; n < 6; n++)
			send_word(pix_word_t'{req_type: REQ_PIXEL, pixel_in: n[0] ? 8'hFF : 8'h00});
		repeat (4) send_word(pix_word_t'{req_type: REQ_DRAIN, pixel_in: 8'hFF});
		settle_block();
	endtask

	// One frame each at the narrowest and shortest sizes, plus one frame wider than the
	// random frames use. Raw values below 2 in either size register must clamp to 2.
	task automatic test_size_extremes();
		int unsigned raw_w [4];
		int unsigned raw_h [4];
		int k;
		raw_w = '{2, 1, 0, 48};
		raw_h = '{1, 2, 3, 0};
		for (k = 0; k < 4; k++) begin
			write_reg(REG_FRAME_WIDTH, 32'(raw_w[k]));
			write_reg(REG_FRAME_HEIGHT, 32'(raw_h[k]));
			write_masks(12'($urandom_range(4095)), 12'($urandom_range(4095)),
				12'($urandom_range(4095)));
			send_frame(2);
			settle_block();
		end
	endtask

	// Mostly well-formed small frames with random content, back to back, and reconfigured
	// between frames about half of the time. A stretch in the middle runs without any idling.
	task automatic test_random_frames();
		int unsigned start;
		int unsigned raw_w;
		int unsigned raw_h;
		start = sent_words;
		while (sent_words < TOTAL_WORDS) begin
			idle_on = !((sent_words - start) >= 300 && (sent_words - start) < 600);
			if ($urandom_range(1) == 0) begin
				settle_block();
				raw_w = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(2, 12);
				raw_h = $urandom_range(2, 6);
				if ($urandom_range(9) == 0)
					raw_w = $urandom_range(1);
				if ($urandom_range(9) == 0)
					raw_h = $urandom_range(1);
				write_reg(REG_FRAME_WIDTH, 32'(raw_w));
				write_reg(REG_FRAME_HEIGHT, 32'(raw_h));
				case ($urandom_range(5))
					0: write_masks(12'h000, 12'h000, 12'h000);
					1: write_masks(12'hFFF, 12'hFFF, 12'hFFF);
					default: write_masks(12'($urandom_range(4095)),
						12'($urandom_range(4095)), 12'($urandom_range(4095)));
				endcase
			end
			send_frame(($urandom_range(3) == 0) ? 8 : 0);
		end
		idle_on = 1'b1;
		settle_block();
	endtask

	// Every taken result word is checked against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (edge_queue.size() == 0) begin
				error_count++;
				$display("%0t unexpected result: expected none, actual %0d/%0d",
					$time, res_word.pixel_out, res_word.frame_last);
			end else begin
				want = edge_queue.pop_front();
				if (res_word.pixel_out !== want.pixel_out) begin
					error_count++;
					$display("%0t pixel_out mismatch: expected %0d, actual %0d",
						$time, want.pixel_out, res_word.pixel_out);
				end
				if (res_word.frame_last !== want.frame_last) begin
					error_count++;
					$display("%0t frame_last mismatch: expected %0d, actual %0d",
						$time, want.frame_last, res_word.frame_last);
				end
			end
		end
	end

	// The receiver stalls at random while idling is on.
	always @(posedge clk)
		res_stall <= idle_on && ($urandom_range(99) < 14);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix_valid <= 1'b0;
		pix_word <= '0;
		sent_words = 0;
		idle_on = 1'b1;

		// The behavioral copy starts from the reset state of the block. The line memory is
		// undefined in the block, but its unwritten entries only ever meet masked taps.
		cfg_width = RST_FRAME_WIDTH;
		cfg_height = RST_FRAME_HEIGHT;
		mask_row[0] = RST_MASK_TOP;
		mask_row[1] = RST_MASK_MIDDLE;
		mask_row[2] = RST_MASK_BOTTOM;
		for (i = 0; i < 2 * MAXW; i++)
			line_mem[i] = 8'd0;
		for (i = 0; i < 9; i++)
			win[i / 3][i % 3] = 8'd0;
		col_in = 0;
		row_in = 0;
		col_out = 0;
		row_out = 0;
		flushing = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_mask();
		test_mask_extremes();
		test_size_extremes();
		test_random_frames();

		settle_block();
		if (error_count == 0 && edge_queue.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
